>>> rtl/npx_pkg.sv
// ----------------------------------------------------------------------------
// npx_pkg
// Shared types and constants for the named parameter extractor.
// ----------------------------------------------------------------------------
package npx_pkg;

  localparam int MAX_NAME_LEN     = 16;
  localparam int DEFAULT_NAME_LEN = 12;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SOURCE_MODE = 2'd0;
  localparam logic [1:0] REG_NAME_LENGTH = 2'd1;
  localparam logic [1:0] REG_CHARS_LOW   = 2'd2;
  localparam logic [1:0] REG_CHARS_HIGH  = 2'd3;

  // characters
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef enum logic [2:0] {
    PH_MATCH,
    PH_SPACES,
    PH_EQ,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic        src_mode;
    logic [4:0]  name_len;
    logic [63:0] chars_lo;
    logic [63:0] chars_hi;
  } cfg_t;

  // results caused by one input word: up to three, the last of them may
  // close the string
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            bv0;
    logic            last;
    logic            found;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> rtl/npx_front.sv
// ----------------------------------------------------------------------------
// npx_front
// Parser: segments the string, matches the name and percent-decodes the
// value, packing the results of each input word into one bundle.
// ----------------------------------------------------------------------------
module npx_front (
  input  logic             clk,
  input  logic             rst_n,
  input  npx_pkg::cfg_t    cfg,
  input  logic             in_fire,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output logic             push,
  output npx_pkg::bundle_t bundle
);

  npx_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic [4:0] mpos_r, mpos_nxt, mpos_step;
  logic [1:0] escc_r, escc_nxt, escc_step;
  logic [7:0] escd_r, escd_nxt, escd_step;
  logic       found_r, found_nxt, found_step;
  logic       first_r, first_nxt;

  logic [7:0] b;
  logic [7:0] sep;
  logic       is_sep;
  logic       drop;
  logic [4:0] len_eff;
  logic [7:0] name_c;
  logic       match_ok;
  logic [4:0] mpos_inc;
  npx_pkg::phase_t start_ph;
  logic       b_hex;
  logic [3:0] b_hv;
  logic       plain_emit;
  logic [7:0] plain_byte;

  logic [2:0]      n;
  logic [4:0][7:0] slots;

  function automatic logic [7:0] dflt_char(input logic [3:0] i);
    case (i)
      4'd0:    dflt_char = 8'h61; // a
      4'd1:    dflt_char = 8'h63; // c
      4'd2:    dflt_char = 8'h63; // c
      4'd3:    dflt_char = 8'h65; // e
      4'd4:    dflt_char = 8'h73; // s
      4'd5:    dflt_char = 8'h73; // s
      4'd6:    dflt_char = 8'h5F; // _
      4'd7:    dflt_char = 8'h74; // t
      4'd8:    dflt_char = 8'h6F; // o
      4'd9:    dflt_char = 8'h6B; // k
      4'd10:   dflt_char = 8'h65; // e
      4'd11:   dflt_char = 8'h6E; // n
      default: dflt_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    fold = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic hex_ok(input logic [7:0] c);
    hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39)      v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else                               v = c - 8'h37;
    hex_val = v[3:0];
  endfunction

  assign b        = in_byte;
  assign sep      = cfg.src_mode ? npx_pkg::CH_AMP : npx_pkg::CH_SEMI;
  assign is_sep   = (b == sep);
  assign drop     = !first_r && cfg.src_mode && (b == npx_pkg::CH_QMARK);
  assign start_ph = cfg.src_mode ? npx_pkg::PH_MATCH : npx_pkg::PH_SPACES;
  assign b_hex    = hex_ok(b);
  assign b_hv     = hex_val(b);
  assign mpos_inc = mpos_r + 5'd1;

  always_comb begin
    if (cfg.name_len == 5'd0)
      len_eff = 5'(npx_pkg::DEFAULT_NAME_LEN);
    else if (cfg.name_len > 5'(npx_pkg::MAX_NAME_LEN))
      len_eff = 5'(npx_pkg::MAX_NAME_LEN);
    else
      len_eff = cfg.name_len;
  end

  always_comb begin
    if (cfg.name_len == 5'd0)
      name_c = dflt_char(mpos_r[3:0]);
    else if (mpos_r[3])
      name_c = cfg.chars_hi[{mpos_r[2:0], 3'b000} +: 8];
    else
      name_c = cfg.chars_lo[{mpos_r[2:0], 3'b000} +: 8];
  end

  assign match_ok   = (mpos_r < len_eff) && (fold(b) == fold(name_c));
  assign plain_emit = !is_sep && (b != npx_pkg::CH_PCT);
  assign plain_byte = (b == npx_pkg::CH_PLUS) ? npx_pkg::CH_SP : b;

  // next state
  always_comb begin
    phase_step = phase_r;
    mpos_step  = mpos_r;
    escc_step  = escc_r;
    escd_step  = escd_r;
    found_step = found_r;
    if (!drop) begin
      case (phase_r)
        npx_pkg::PH_MATCH, npx_pkg::PH_SPACES: begin
          if (phase_r == npx_pkg::PH_SPACES && b == npx_pkg::CH_SP) begin
            phase_step = phase_r;
          end else if (is_sep) begin
            mpos_step  = 5'd0;
            phase_step = start_ph;
          end else if (match_ok) begin
            mpos_step  = mpos_inc;
            phase_step = (mpos_inc >= len_eff) ? npx_pkg::PH_EQ : npx_pkg::PH_MATCH;
          end else begin
            phase_step = npx_pkg::PH_SKIP;
          end
        end
        npx_pkg::PH_EQ: begin
          if (b == npx_pkg::CH_EQ) begin
            phase_step = npx_pkg::PH_VALUE;
            found_step = 1'b1;
            escc_step  = 2'd0;
          end else if (is_sep) begin
            mpos_step  = 5'd0;
            phase_step = start_ph;
          end else begin
            phase_step = npx_pkg::PH_SKIP;
          end
        end
        npx_pkg::PH_SKIP: begin
          if (is_sep) begin
            mpos_step  = 5'd0;
            phase_step = start_ph;
          end
        end
        npx_pkg::PH_VALUE: begin
          // a held escape that breaks falls back to treating b as plain
          if (escc_r == 2'd1 && b_hex) begin
            escd_step = b;
            escc_step = 2'd2;
          end else if (escc_r == 2'd2 && b_hex) begin
            escc_step = 2'd0;
          end else begin
            escc_step = 2'd0;
            if (is_sep)                     phase_step = npx_pkg::PH_DONE;
            else if (b == npx_pkg::CH_PCT)  escc_step  = 2'd1;
          end
        end
        default: begin
          phase_step = phase_r;
        end
      endcase
    end

    if (in_last) begin
      phase_nxt = npx_pkg::PH_MATCH;
      mpos_nxt  = 5'd0;
      escc_nxt  = 2'd0;
      escd_nxt  = 8'd0;
      found_nxt = 1'b0;
      first_nxt = 1'b0;
    end else begin
      phase_nxt = phase_step;
      mpos_nxt  = mpos_step;
      escc_nxt  = escc_step;
      escd_nxt  = escd_step;
      found_nxt = found_step;
      first_nxt = 1'b1;
    end
  end

  // results of this word
  always_comb begin
    n     = 3'd0;
    slots = '0;
    if (!drop && phase_r == npx_pkg::PH_VALUE) begin
      case (escc_r)
        2'd0: begin
          if (plain_emit) begin
            slots[n] = plain_byte; n = n + 3'd1;
          end
        end
        2'd1: begin
          if (!b_hex) begin
            slots[n] = npx_pkg::CH_PCT; n = n + 3'd1;
            if (plain_emit) begin
              slots[n] = plain_byte; n = n + 3'd1;
            end
          end
        end
        default: begin
          if (b_hex) begin
            slots[n] = {hex_val(escd_r), b_hv}; n = n + 3'd1;
          end else begin
            slots[n] = npx_pkg::CH_PCT; n = n + 3'd1;
            slots[n] = escd_r;          n = n + 3'd1;
            if (plain_emit) begin
              slots[n] = plain_byte; n = n + 3'd1;
            end
          end
        end
      endcase
    end
    // unfinished escape at the end goes out literally
    if (in_last) begin
      if (escc_step != 2'd0) begin
        slots[n] = npx_pkg::CH_PCT; n = n + 3'd1;
      end
      if (escc_step == 2'd2) begin
        slots[n] = escd_step; n = n + 3'd1;
      end
    end
  end

  always_comb begin
    bundle.bytes = slots[2:0];
    bundle.bv0   = (n != 3'd0);
    bundle.last  = in_last;
    bundle.found = found_step;
    if (n >= 3'd3)      bundle.cnt = 2'd3;
    else if (n == 3'd0) bundle.cnt = 2'd1; // end-only result
    else                bundle.cnt = n[1:0];
  end

  assign push = in_fire && ((n != 3'd0) || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= npx_pkg::PH_MATCH;
      mpos_r  <= 5'd0;
      escc_r  <= 2'd0;
      escd_r  <= 8'd0;
      found_r <= 1'b0;
      first_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      mpos_r  <= mpos_nxt;
      escc_r  <= escc_nxt;
      escd_r  <= escd_nxt;
      found_r <= found_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

>>> rtl/npx_queue.sv
// ----------------------------------------------------------------------------
// npx_queue
// Small bundle queue between parser and output serializer.
// ----------------------------------------------------------------------------
module npx_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  npx_pkg::bundle_t   push_data,
  input  logic               pop,
  output npx_pkg::bundle_t   head,
  output npx_pkg::q_status_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  npx_pkg::bundle_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] fill_r;

  assign stat.full  = (fill_r == CNT_W'(DEPTH));
  assign stat.empty = (fill_r == '0);
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      fill_r <= fill_r + CNT_W'(1);
      else if (pop && !push) fill_r <= fill_r - CNT_W'(1);
    end
  end

endmodule

>>> rtl/npx_back.sv
// ----------------------------------------------------------------------------
// npx_back
// Serializer: walks the head bundle into the output register one result
// per cycle while out_tready does not stall the output.
// ----------------------------------------------------------------------------
module npx_back (
  input  logic             clk,
  input  logic             rst_n,
  input  npx_pkg::bundle_t head,
  input  logic             head_valid,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic [1:0] slot_r, slot_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r;
  logic [1:0] user_r;
  logic       last_r;
  logic       load;
  logic       last_slot;

  assign load      = head_valid && (!valid_r || out_tready);
  assign last_slot = (slot_r == head.cnt - 2'd1);
  assign pop       = load && last_slot;

  always_comb begin
    slot_nxt = slot_r;
    if (load) slot_nxt = last_slot ? 2'd0 : slot_r + 2'd1;
    if (load)            valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
    else                 valid_nxt = valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      slot_r  <= slot_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r    <= head.bytes[slot_r];
      user_r[0] <= (slot_r == 2'd0) ? head.bv0 : 1'b1;
      user_r[1] <= head.found && head.last && last_slot;
      last_r    <= head.last && last_slot;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

>>> rtl/named_param_extract_url_decode.sv
// ----------------------------------------------------------------------------
// named_param_extract_url_decode
// Finds a named cookie or query parameter in a byte stream and emits its
// percent-decoded value, then a found flag on the final result.
// Path: the results of an accepted word are written to the queue, then
// loaded one by one into the output register.
// Throughput: one input word per cycle while the queue is not full; output
// one result per cycle while out_tready is high; the QUEUE_DEPTH-bundle
// queue (four by default) between parser and serializer absorbs bursts.
// Reset: synchronous rst_n clears registers, parse state, queue, output.
// ----------------------------------------------------------------------------
module named_param_extract_url_decode #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] value_byte
  output logic [1:0]  out_tuser,  // [0] byte_valid, [1] found
  output logic        out_tlast,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_wdata
);

  npx_pkg::cfg_t      cfg_r;
  npx_pkg::bundle_t   q_in;
  npx_pkg::bundle_t   q_head;
  npx_pkg::q_status_t q_stat;
  logic               q_push;
  logic               q_pop;
  logic               in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        npx_pkg::REG_SOURCE_MODE: cfg_r.src_mode <= cfg_wdata[0];
        npx_pkg::REG_NAME_LENGTH: cfg_r.name_len <= cfg_wdata[4:0];
        npx_pkg::REG_CHARS_LOW:   cfg_r.chars_lo <= cfg_wdata;
        npx_pkg::REG_CHARS_HIGH:  cfg_r.chars_hi <= cfg_wdata;
        default:                  cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_tready = !q_stat.full;
  assign in_fire   = in_tvalid && in_tready;

  npx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .push    (q_push),
    .bundle  (q_in)
  );

  npx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  npx_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_stat.empty),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_found_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("found flag away from final result");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tdata == 8'd0))
    else $error("result without byte is not a clean final result");

endmodule
